// File: hw/rtl/radix_digit_string_converter_core_defines.svh
// ----------------------------------------------------------------------------
// Radix digit string converter: assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_STRING_CONVERTER_CORE_DEFINES_SVH
`define RADIX_DIGIT_STRING_CONVERTER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define RDSC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RDSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define RDSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit string converter: package
// Widths, register indexes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    localparam int VALUE_W        = 64;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int ALPHA_WORDS    = 4;
    localparam int ALPHA_CHARS    = ALPHA_WORDS * (VALUE_W / CHAR_W);
    localparam int CFG_IDX_W      = 3;
    localparam int DIV_BITS       = 8;
    localparam int DIV_CYCLES     = VALUE_W / DIV_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    localparam int DEF_MAX_RADIX  = 32;
    localparam int DEF_MAX_DIGITS = 64;

    localparam logic [RADIX_W-1:0] RADIX_RST  = RADIX_W'(10);
    localparam logic [VALUE_W-1:0] ALPHA0_RST = 64'd4050765991979987505;
    localparam logic [VALUE_W-1:0] ALPHA1_RST = 64'd14648;
    localparam logic [VALUE_W-1:0] ALPHA2_RST = 64'd0;
    localparam logic [VALUE_W-1:0] ALPHA3_RST = 64'd0;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA3 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ERROR,
        ST_DIVIDE,
        ST_DIGIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic chk_next;
        logic div_step;
        logic digit_end;
        logic emit_rd;
        logic emit_err;
    } dp_cmd_t;

    typedef struct packed {
        logic r_lt2;
        logic dup;
        logic chk_end;
        logic div_last;
        logic q_zero;
        logic cnt_end;
        logic p_zero;
    } dp_stat_t;

endpackage

// File: hw/rtl/rdsc_datapath.sv
// ----------------------------------------------------------------------------
// Radix digit string converter: datapath
// Config registers, alphabet duplicate check, iterative divider, digit store
// and output registers.
// ----------------------------------------------------------------------------
`include "radix_digit_string_converter_core_defines.svh"

module rdsc_datapath #(
    parameter int MAX_RADIX  = rdsc_pkg::DEF_MAX_RADIX,
    parameter int MAX_DIGITS = rdsc_pkg::DEF_MAX_DIGITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [rdsc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [rdsc_pkg::VALUE_W-1:0]        wr_data,
    input  logic [rdsc_pkg::VALUE_W-1:0]        value,
    input  rdsc_pkg::dp_cmd_t                   cmd,
    output rdsc_pkg::dp_stat_t                  stat,
    output logic                                strobe,
    output logic [rdsc_pkg::CHAR_W-1:0]         char_out,
    output logic                                last,
    output logic                                error
);

    localparam int IW = $clog2(MAX_RADIX);
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int RW = rdsc_pkg::RADIX_W;
    localparam int VW = rdsc_pkg::VALUE_W;
    localparam int CHW = rdsc_pkg::CHAR_W;

    logic [RW-1:0]                                  radix_reg;
    logic [rdsc_pkg::ALPHA_WORDS-1:0][VW-1:0]       alpha_reg;
    logic [rdsc_pkg::ALPHA_WORDS*VW-1:0]            alpha_flat;
    logic [CHW-1:0]                                 alpha [MAX_RADIX];
    logic [RW-1:0]                                  r_eff;

    logic [IW-1:0]                      chk_idx_reg;
    logic [VW-1:0]                      acc_reg;
    logic [VW-1:0]                      acc_next;
    logic [RW-1:0]                      rem_reg;
    logic [RW-1:0]                      rem_next;
    logic [rdsc_pkg::DIV_CNT_W-1:0]     step_reg;
    logic [CW-1:0]                      cnt_reg;
    logic [AW-1:0]                      ptr_reg;
    logic                               dup;

    logic [CHW-1:0]                     mem [MAX_DIGITS];
    logic [CHW-1:0]                     rdata_reg;
    logic                               strobe_reg;
    logic                               last_reg;
    logic                               error_reg;

    assign alpha_flat = alpha_reg;
    assign r_eff = ({1'b0, radix_reg} > (RW + 1)'(MAX_RADIX)) ? RW'(MAX_RADIX) : radix_reg;

    genvar k;
    for (k = 0; k < MAX_RADIX; k++)
    begin : g_alpha
        if (k < rdsc_pkg::ALPHA_CHARS)
        begin : g_stored
            assign alpha[k] = alpha_flat[k*CHW +: CHW];
        end
        else
        begin : g_blank
            assign alpha[k] = '0;
        end
    end

    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < MAX_RADIX; j++)
        begin
            if ((IW'(j) < chk_idx_reg) && (alpha[j] == alpha[chk_idx_reg]))
            begin
                dup = 1'b1;
            end
        end
    end

    // restoring division, DIV_BITS quotient bits a cycle
    always_comb
    begin
        logic [RW:0] trial;
        acc_next = acc_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int b = 0; b < rdsc_pkg::DIV_BITS; b++)
        begin
            trial    = {rem_next, acc_next[VW-1]};
            acc_next = {acc_next[VW-2:0], 1'b0};
            if (trial >= {1'b0, r_eff})
            begin
                rem_next    = RW'(trial - {1'b0, r_eff});
                acc_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[RW-1:0];
            end
        end
    end

    always_comb
    begin
        stat.r_lt2    = r_eff < RW'(2);
        stat.dup      = dup;
        stat.chk_end  = RW'(chk_idx_reg) == (r_eff - RW'(1));
        stat.div_last = step_reg == rdsc_pkg::DIV_CNT_W'(rdsc_pkg::DIV_CYCLES - 1);
        stat.q_zero   = acc_reg == '0;
        stat.cnt_end  = cnt_reg == CW'(MAX_DIGITS - 1);
        stat.p_zero   = ptr_reg == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= rdsc_pkg::RADIX_RST;
            alpha_reg[0] <= rdsc_pkg::ALPHA0_RST;
            alpha_reg[1] <= rdsc_pkg::ALPHA1_RST;
            alpha_reg[2] <= rdsc_pkg::ALPHA2_RST;
            alpha_reg[3] <= rdsc_pkg::ALPHA3_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rdsc_pkg::REG_RADIX:  radix_reg    <= wr_data[RW-1:0];
                rdsc_pkg::REG_ALPHA0: alpha_reg[0] <= wr_data;
                rdsc_pkg::REG_ALPHA1: alpha_reg[1] <= wr_data;
                rdsc_pkg::REG_ALPHA2: alpha_reg[2] <= wr_data;
                rdsc_pkg::REG_ALPHA3: alpha_reg[3] <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_idx_reg <= '0;
            rem_reg     <= '0;
            step_reg    <= '0;
            cnt_reg     <= '0;
            ptr_reg     <= '0;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
            error_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_rd | cmd.emit_err;
            last_reg   <= cmd.emit_err | (cmd.emit_rd & stat.p_zero);
            error_reg  <= cmd.emit_err;
            if (cmd.load)
            begin
                chk_idx_reg <= IW'(1);
                rem_reg     <= '0;
                step_reg    <= '0;
                cnt_reg     <= '0;
            end
            if (cmd.chk_next)
            begin
                chk_idx_reg <= chk_idx_reg + IW'(1);
            end
            if (cmd.div_step)
            begin
                rem_reg  <= rem_next;
                step_reg <= step_reg + rdsc_pkg::DIV_CNT_W'(1);
            end
            if (cmd.digit_end)
            begin
                rem_reg  <= '0;
                step_reg <= '0;
                cnt_reg  <= cnt_reg + CW'(1);
                ptr_reg  <= cnt_reg[AW-1:0];
            end
            if (cmd.emit_rd)
            begin
                ptr_reg <= ptr_reg - AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= value;
        end
        else if (cmd.div_step)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.digit_end)
        begin
            mem[cnt_reg[AW-1:0]] <= alpha[rem_reg[IW-1:0]];
        end
        if (cmd.emit_rd)
        begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    assign strobe   = strobe_reg;
    assign char_out = error_reg ? '0 : rdata_reg;
    assign last     = last_reg;
    assign error    = error_reg;

    `RDSC_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(MAX_DIGITS), "digit count past store depth")
    `RDSC_ASSERT_SAME(a_err_last, strobe_reg && error_reg, last_reg, "error beat not marked last")
    `RDSC_ASSERT_NEXT(a_final_beat, cmd.emit_rd && stat.p_zero, strobe_reg && last_reg,
                      "final digit read not followed by last beat")

endmodule

// File: hw/rtl/rdsc_ctrl.sv
// ----------------------------------------------------------------------------
// Radix digit string converter: controller
// Sequences alphabet check, digit division and digit emission.
// ----------------------------------------------------------------------------
`include "radix_digit_string_converter_core_defines.svh"

module rdsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rdsc_pkg::dp_stat_t  stat,
    output rdsc_pkg::dp_cmd_t   cmd,
    output logic                busy
);

    rdsc_pkg::state_t state_reg;
    rdsc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdsc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            rdsc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = rdsc_pkg::ST_CHECK;
                end
            end
            rdsc_pkg::ST_CHECK:
            begin
                if (stat.r_lt2 || stat.dup)
                begin
                    state_next = rdsc_pkg::ST_ERROR;
                end
                else if (stat.chk_end)
                begin
                    state_next = rdsc_pkg::ST_DIVIDE;
                end
                else
                begin
                    cmd.chk_next = 1'b1;
                end
            end
            rdsc_pkg::ST_ERROR:
            begin
                cmd.emit_err = 1'b1;
                state_next   = rdsc_pkg::ST_IDLE;
            end
            rdsc_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = rdsc_pkg::ST_DIGIT;
                end
            end
            rdsc_pkg::ST_DIGIT:
            begin
                cmd.digit_end = 1'b1;
                if (stat.q_zero || stat.cnt_end)
                begin
                    state_next = rdsc_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = rdsc_pkg::ST_DIVIDE;
                end
            end
            rdsc_pkg::ST_EMIT:
            begin
                cmd.emit_rd = 1'b1;
                if (stat.p_zero)
                begin
                    state_next = rdsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != rdsc_pkg::ST_IDLE;

    `RDSC_ASSERT_NEXT(a_start_check, start && !busy, state_reg == rdsc_pkg::ST_CHECK,
                      "accepted start did not enter check")
    `RDSC_ASSERT_NEXT(a_err_single, state_reg == rdsc_pkg::ST_ERROR,
                      state_reg == rdsc_pkg::ST_IDLE, "error beat not single")

endmodule

// File: hw/rtl/radix_digit_string_converter_core.sv
// ----------------------------------------------------------------------------
// Radix digit string converter: top level
// Converts a 64-bit value to alphabet characters in a configured radix.
// ----------------------------------------------------------------------------
// Sequence: a load, an alphabet check of each radix position, then per digit
//   divider steps of 8 bits each and a store, then one read per digit; the
//   first beat follows the final store through the emit state and the output
//   registers. An error beat follows a failed check through the error state and
//   the output registers. One value at a time; results cannot be stalled.
// Reset: asynchronous, active low; radix 10 and the package reset alphabet.

module radix_digit_string_converter_core #(
    parameter int MAX_RADIX  = rdsc_pkg::DEF_MAX_RADIX,
    parameter int MAX_DIGITS = rdsc_pkg::DEF_MAX_DIGITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rdsc_pkg::VALUE_W-1:0]    value,
    input  logic                            wr_en,
    input  logic [rdsc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [rdsc_pkg::VALUE_W-1:0]    wr_data,
    output logic                            strobe,
    output logic [rdsc_pkg::CHAR_W-1:0]     char_out,
    output logic                            last,
    output logic                            error
);

    rdsc_pkg::dp_cmd_t  cmd;
    rdsc_pkg::dp_stat_t stat;

    rdsc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rdsc_datapath #(
        .MAX_RADIX  (MAX_RADIX),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .value    (value),
        .cmd      (cmd),
        .stat     (stat),
        .strobe   (strobe),
        .char_out (char_out),
        .last     (last),
        .error    (error)
    );

endmodule
